/* hdl/sapg_pkg.sv */
// Shared types and constants for the stepper angle pulse generator.
// No dependencies; every other file imports this package.
package sapg_pkg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } opcode_t;

    // Command handed from the front pipeline to the executor.
    typedef struct packed {
        logic        is_move;
        logic        dir;
        logic [15:0] steps;
    } cmd_t;

    localparam int ANGLE_W   = 24;
    localparam int STEP_W    = 16;
    localparam int SPR_W     = 16;
    localparam int PROD_W    = ANGLE_W + SPR_W;

    localparam logic [SPR_W-1:0]  SPR_RESET = 16'd400;
    localparam logic [STEP_W-1:0] STEP_MAX  = 16'hFFFF;

    // 36000 = 32 * 1125. Low five bits are shifted off, then a reciprocal
    // multiply by ceil(2^38 / 1125) gives the exact quotient for any
    // dividend below 2^27.
    localparam int QUOT_SHIFT = 5;
    localparam int DIVD_W     = 27;
    localparam int RECIP_W    = 28;
    localparam int RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 28'd244335918;

    // 65536 * 36000: any product at or above this saturates
    localparam logic [PROD_W-1:0] SAT_LIMIT = 40'd2359296000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* hdl/sapg_front.sv */
// Front pipeline: accepts transactions, tracks the commanded angle and
// converts a move into direction and step count. Depends on sapg_pkg.
module sapg_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,   // opcode
    input  logic [23:0]           s_tdata,   // target_angle
    output logic                  push_valid,
    output sapg_pkg::cmd_t        push_cmd,
    input  logic                  q_full
);
    import sapg_pkg::*;

    logic [SPR_W-1:0]   spr_reg;
    logic [ANGLE_W-1:0] angle_reg;

    logic               s1_valid_reg, s1_move_reg, s1_dir_reg;
    logic [ANGLE_W-1:0] s1_mag_reg;
    logic               s2_valid_reg, s2_move_reg, s2_dir_reg;
    logic [PROD_W-1:0]  s2_prod_reg;
    logic               s3_valid_reg, s3_move_reg, s3_dir_reg;
    logic [STEP_W-1:0]  s3_steps_reg;

    logic                        adv;
    logic                        in_move;
    logic signed [ANGLE_W:0]     diff;
    logic [ANGLE_W:0]            mag_full;
    logic [DIVD_W-1:0]           divd;
    logic [DIVD_W+RECIP_W-1:0]   qprod;
    logic [STEP_W-1:0]           steps_next;

    assign adv      = !s3_valid_reg || !q_full;
    assign s_tready = adv;
    assign in_move  = (s_tuser == OP_MOVE);

    assign diff     = $signed({s_tdata[ANGLE_W-1], s_tdata})
                    - $signed({angle_reg[ANGLE_W-1], angle_reg});
    assign mag_full = diff[ANGLE_W] ? (~diff + 1'b1) : diff;

    assign divd  = s2_prod_reg[QUOT_SHIFT +: DIVD_W];
    assign qprod = divd * RECIP_MULT;
    assign steps_next = (s2_prod_reg >= SAT_LIMIT) ? STEP_MAX
                                                   : qprod[RECIP_SHIFT +: STEP_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg      <= SPR_RESET;
            angle_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spr_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                if (s_tvalid && in_move)
                begin
                    angle_reg <= s_tdata;
                end
                s1_valid_reg <= s_tvalid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_move_reg  <= in_move;
            s1_dir_reg   <= ~diff[ANGLE_W];
            s1_mag_reg   <= mag_full[ANGLE_W-1:0];
            s2_move_reg  <= s1_move_reg;
            s2_dir_reg   <= s1_dir_reg;
            s2_prod_reg  <= s1_mag_reg * spr_reg;
            s3_move_reg  <= s2_move_reg;
            s3_dir_reg   <= s2_dir_reg;
            s3_steps_reg <= steps_next;
        end
    end

    assign push_valid       = s3_valid_reg && !q_full;
    assign push_cmd.is_move = s3_move_reg;
    assign push_cmd.dir     = s3_dir_reg;
    assign push_cmd.steps   = s3_steps_reg;

endmodule

/* hdl/sapg_queue.sv */
// Short command queue between the front pipeline and the executor.
// Depends on sapg_pkg.
module sapg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sapg_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sapg_pkg::cmd_t  head_cmd
);
    import sapg_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");
`endif

endmodule

/* hdl/sapg_back.sv */
// Executor: applies moves and ticks to the pulse state and holds the
// result in an output register. Depends on sapg_pkg.
module sapg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  sapg_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata    // step_level, direction, running, move_done, pad
);
    import sapg_pkg::*;

    logic [STEP_W-1:0] target_steps_reg, target_steps_next;
    logic [STEP_W-1:0] steps_done_reg, steps_done_next;
    logic              phase_reg, phase_next;
    logic              run_reg, run_next;
    logic              dir_reg, dir_next;
    logic              done_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_done_reg;
    logic [STEP_W-1:0] steps_inc;

    assign pop       = head_valid && (!out_valid_reg || m_tready);
    assign steps_inc = steps_done_reg + 1'b1;

    always_comb
    begin
        target_steps_next = target_steps_reg;
        steps_done_next   = steps_done_reg;
        phase_next        = phase_reg;
        run_next          = run_reg;
        dir_next          = dir_reg;
        done_next         = 1'b0;
        if (head_cmd.is_move)
        begin
            dir_next          = head_cmd.dir;
            target_steps_next = head_cmd.steps;
            steps_done_next   = '0;
            phase_next        = 1'b0;
            run_next          = (head_cmd.steps != '0);
        end
        else if (run_reg)
        begin
            if (!phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next      = 1'b0;
                steps_done_next = steps_inc;
                if (steps_inc >= target_steps_reg)
                begin
                    run_next        = 1'b0;
                    steps_done_next = '0;
                    done_next       = 1'b1;
                end
            end
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_steps_reg <= '0;
            steps_done_reg   <= '0;
            phase_reg        <= 1'b0;
            run_reg          <= 1'b0;
            dir_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                target_steps_reg <= target_steps_next;
                steps_done_reg   <= steps_done_next;
                phase_reg        <= phase_next;
                run_reg          <= run_next;
                dir_reg          <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_done_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_done_reg, run_reg, dir_reg, phase_reg};

`ifndef SYNTHESIS
    a_count_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (steps_done_reg < target_steps_reg))
        else $error("step count reached target while running");
    a_idle_step_low: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> (!phase_reg && steps_done_reg == '0))
        else $error("step pin high or count nonzero while idle");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (!run_reg && !phase_reg))
        else $error("move done reported with run still active");
`endif

endmodule

/* hdl/stepper_angle_pulse_generator.sv */
// Top level of the single-axis stepper step/direction pulse generator.
// Depends on sapg_pkg, sapg_front, sapg_queue and sapg_back.

// Each input transaction is a timer tick (tuser 0) or a move to a target
// angle in 0.01 degree (tuser 1); each gives exactly one result carrying the
// step pin, direction pin, running flag and move-done flag. One transaction
// is taken every clock while the result side keeps up; a result passes through
// the three-stage angle to step conversion (steps_per_rev multiply, then a
// reciprocal multiply for the divide by 36000), one queue slot and the output
// register. The four-entry queue absorbs stalls on the result side before
// input is held off.
// steps_per_rev may only be written while no transaction is in flight.
module stepper_angle_pulse_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // steps_per_rev
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,       // opcode
    input  logic [23:0] s_tdata,       // target_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // step_level, direction, running, move_done, pad
);
    import sapg_pkg::*;

    logic push_valid;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    sapg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    sapg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sapg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
